>>> design/modified_julian_day_to_calendar_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the MJD to calendar converter
// Concurrent checks on a clock with an active-low reset; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef MODIFIED_JULIAN_DAY_TO_CALENDAR_DEFINES_SVH
`define MODIFIED_JULIAN_DAY_TO_CALENDAR_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define MJDC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mjdc assertion failed");
// next-cycle implication
`define MJDC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mjdc assertion failed");
`else
`define MJDC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define MJDC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> design/mjdc_pkg.sv
// ----------------------------------------------------------------------------
// mjdc_pkg
// Widths, constants and payload types of the MJD to calendar converter.
// Constant divisions use exact reciprocals: floor(x*C/D) = (x*R) >> S with
// R = ceil(C*2^S/D) and S = width(x) + clog2(D).
// ----------------------------------------------------------------------------
package mjdc_pkg;

	localparam int FRAC_BITS  = 40;
	localparam int DAY_BITS   = 20;
	localparam int NUM_STAGES = 9;

	localparam int YEAR_W   = 13;
	localparam int MONTH_W  = 4;
	localparam int MDAY_W   = 5;
	localparam int HOUR_W   = 5;
	localparam int MINUTE_W = 6;
	localparam int SEC_W    = 23;

	// time of day scaling: 8640000000 = 2^11 * 4218750
	localparam longint unsigned SCALE_ODD = 64'd4218750;
	localparam int SCALE_W     = 23;
	localparam int SCALE_SHIFT = FRAC_BITS - 11;
	localparam int LO_BITS     = FRAC_BITS / 2;
	localparam int HI_BITS     = FRAC_BITS - LO_BITS;
	localparam int LO_P_W      = LO_BITS + SCALE_W;
	localparam int HI_P_W      = HI_BITS + SCALE_W;
	localparam int SUM_W       = FRAC_BITS + SCALE_W + 1;
	localparam int UNITS_W     = 34;
	localparam longint unsigned UNITS_PER_DAY    = 64'd8640000000;
	localparam longint unsigned UNITS_PER_HOUR   = 64'd360000000;
	localparam longint unsigned UNITS_PER_MINUTE = 64'd6000000;

	// hour = (units >> 9) / 703125
	localparam int HOUR_X_SHIFT = 9;
	localparam int HOUR_X_W     = UNITS_W - HOUR_X_SHIFT;
	localparam longint unsigned HOUR_DIV = 64'd703125;
	localparam int HOUR_S   = HOUR_X_W + 20;
	localparam longint unsigned HOUR_R = ((64'd1 << HOUR_S) + HOUR_DIV - 64'd1) / HOUR_DIV;
	localparam int HOUR_P_W = HOUR_S + HOUR_W;
	localparam int REM_H_W  = 29;

	// minute = (rem >> 7) / 46875
	localparam int MIN_X_SHIFT = 7;
	localparam int MIN_X_W     = REM_H_W - MIN_X_SHIFT;
	localparam longint unsigned MIN_DIV = 64'd46875;
	localparam int MIN_S   = MIN_X_W + 16;
	localparam longint unsigned MIN_R = ((64'd1 << MIN_S) + MIN_DIV - 64'd1) / MIN_DIV;
	localparam int MIN_P_W = MIN_S + MINUTE_W;

	// day number to Gregorian date
	localparam longint unsigned DAY_OFFSET = 64'd2468570;
	localparam int TW    = ((DAY_BITS > 21) ? DAY_BITS : 21) + 2;
	localparam int CYC_W = TW + 2;

	localparam longint unsigned N_MUL = 64'd4;
	localparam longint unsigned N_DIV = 64'd146097;
	localparam int N_S   = TW + 18;
	localparam longint unsigned N_R = ((N_MUL << N_S) + N_DIV - 64'd1) / N_DIV;
	localparam int NW    = TW - 14;
	localparam int N_P_W = N_S + NW;
	localparam longint unsigned CYCLE_DAYS = 64'd146097;

	localparam int L1W   = 16;
	localparam int Y1_XW = L1W + 1;
	localparam longint unsigned Y1_MUL = 64'd4000;
	localparam longint unsigned Y1_DIV = 64'd1461001;
	localparam int Y1_S   = Y1_XW + 21;
	localparam longint unsigned Y1_R = ((Y1_MUL << Y1_S) + Y1_DIV - 64'd1) / Y1_DIV;
	localparam int Y1W    = 7;
	localparam int Y1_P_W = Y1_S + Y1W;

	localparam longint unsigned QUAD_YEAR_DAYS = 64'd1461;
	localparam longint unsigned MARCH_BIAS     = 64'd31;
	localparam int L2_CALC_W = L1W + 2;
	localparam int L2W       = 10;

	localparam longint unsigned M1_MUL = 64'd80;
	localparam longint unsigned M1_DIV = 64'd2447;
	localparam int M1_S   = L2W + 12;
	localparam longint unsigned M1_R = ((M1_MUL << M1_S) + M1_DIV - 64'd1) / M1_DIV;
	localparam int M1W    = 4;
	localparam int M1_P_W = M1_S + M1W;

	localparam longint unsigned DD_MUL = 64'd2447;
	localparam longint unsigned DD_DIV = 64'd80;
	localparam int DD_S   = M1W + 7;
	localparam longint unsigned DD_R = ((DD_MUL << DD_S) + DD_DIV - 64'd1) / DD_DIV;
	localparam int DD_Q_W = 9;
	localparam int DD_P_W = DD_S + DD_Q_W;

	localparam longint unsigned L3_DIV = 64'd11;
	localparam int L3_S   = M1W + 4;
	localparam longint unsigned L3_R = ((64'd1 << L3_S) + L3_DIV - 64'd1) / L3_DIV;
	localparam int L3_P_W = L3_S + 1;

	localparam longint unsigned MONTH_BIAS    = 64'd2;
	localparam longint unsigned YEAR_MONTHS   = 64'd12;
	localparam longint unsigned CENTURY_YEARS = 64'd100;
	localparam longint unsigned YEAR_BIAS     = 64'd4900;

	typedef struct packed {
		logic [HOUR_W-1:0]   hour;
		logic [MINUTE_W-1:0] minute;
		logic [SEC_W-1:0]    second_units;
	} tod_t;

	typedef struct packed {
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [MDAY_W-1:0]  day_of_month;
	} cal_date_t;

endpackage

>>> design/mjdc_in_if.sv
// ----------------------------------------------------------------------------
// mjdc_in_if
// Valid/ready channel carrying one Modified Julian Date.
// ----------------------------------------------------------------------------
interface mjdc_in_if;
	logic                              valid;
	logic                              ready;
	logic [mjdc_pkg::DAY_BITS-1:0]     mjd_day;
	logic [mjdc_pkg::FRAC_BITS-1:0]    day_fraction;

	modport source (output valid, output mjd_day, output day_fraction, input ready);
	modport sink (input valid, input mjd_day, input day_fraction, output ready);
endinterface

>>> design/mjdc_out_if.sv
// ----------------------------------------------------------------------------
// mjdc_out_if
// Valid/ready channel carrying one calendar date and time of day.
// ----------------------------------------------------------------------------
interface mjdc_out_if;
	logic                              valid;
	logic                              ready;
	logic [mjdc_pkg::YEAR_W-1:0]       year;
	logic [mjdc_pkg::MONTH_W-1:0]      month;
	logic [mjdc_pkg::MDAY_W-1:0]       day_of_month;
	logic [mjdc_pkg::HOUR_W-1:0]       hour;
	logic [mjdc_pkg::MINUTE_W-1:0]     minute;
	logic [mjdc_pkg::SEC_W-1:0]        second_units;

	modport source (output valid, output year, output month, output day_of_month,
		output hour, output minute, output second_units, input ready);
	modport sink (input valid, input year, input month, input day_of_month,
		input hour, input minute, input second_units, output ready);
endinterface

>>> design/modified_julian_day_to_calendar.sv
// ----------------------------------------------------------------------------
// modified_julian_day_to_calendar
// Modified Julian Date to Gregorian date and time of day.
//
// Channel mjd takes a whole day number and a 2^-40 day fraction; channel cal
// returns year, month, day of month, hour, minute and seconds within the
// minute in 10 us units. The fraction is rounded half up; a rounded full day
// rolls into the next date.
// One transaction leaves cal for every transaction taken on mjd, in order.
// Each transaction passes through the nine register stages of the date path
// and the time path before cal.valid rises. Throughput is one transaction
// per cycle while cal does not stall.
// Reset clears the stage valid bits only; the data registers are not reset.
// When cal.ready is low with a result waiting, every stage holds and
// mjd.ready drops in the same cycle; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`include "modified_julian_day_to_calendar_defines.svh"

module modified_julian_day_to_calendar (
	input  logic              clk,
	input  logic              arst_n,
	mjdc_in_if.sink           mjd,
	mjdc_out_if.source        cal
);

	logic                            adv;
	logic [mjdc_pkg::NUM_STAGES-1:0] vld_s;
	logic                            day_carry;
	mjdc_pkg::tod_t                  tod;
	mjdc_pkg::cal_date_t             cal_date;

	assign adv       = !vld_s[mjdc_pkg::NUM_STAGES-1] || cal.ready;
	assign mjd.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[mjdc_pkg::NUM_STAGES-2:0], mjd.valid};
		end
	end

	mjdc_time_pipe u_time (
		.clk          (clk),
		.adv          (adv),
		.day_fraction (mjd.day_fraction),
		.day_carry    (day_carry),
		.tod          (tod)
	);

	mjdc_date_pipe u_date (
		.clk       (clk),
		.adv       (adv),
		.mjd_day   (mjd.mjd_day),
		.day_carry (day_carry),
		.cal_date  (cal_date)
	);

	assign cal.valid        = vld_s[mjdc_pkg::NUM_STAGES-1];
	assign cal.year         = cal_date.year;
	assign cal.month        = cal_date.month;
	assign cal.day_of_month = cal_date.day_of_month;
	assign cal.hour         = tod.hour;
	assign cal.minute       = tod.minute;
	assign cal.second_units = tod.second_units;

	`MJDC_ASSERT_NEXT(a_accept_enters, clk, arst_n, mjd.valid && mjd.ready, vld_s[0])
	`MJDC_ASSERT_NEXT(a_stall_holds, clk, arst_n, !adv, $stable(vld_s))
	`MJDC_ASSERT_IMPL(a_date_range, clk, arst_n, cal.valid, (cal.month >= 4'd1) && (cal.month <= 4'd12) && (cal.day_of_month >= 5'd1))
	`MJDC_ASSERT_IMPL(a_time_range, clk, arst_n, cal.valid, (cal.hour <= 5'd23) && (cal.minute <= 6'd59) && (cal.second_units < 23'd6000000))

endmodule

>>> design/mjdc_time_pipe.sv
// ----------------------------------------------------------------------------
// mjdc_time_pipe
// Day fraction to hour, minute and 10 us seconds, nine register stages.
// Flags the carry of a rounded full day into the day number.
// ----------------------------------------------------------------------------
module mjdc_time_pipe (
	input  logic                           clk,
	input  logic                           adv,
	input  logic [mjdc_pkg::FRAC_BITS-1:0] day_fraction,
	output logic                           day_carry,
	output mjdc_pkg::tod_t                 tod
);

	logic [mjdc_pkg::LO_P_W-1:0]   lo_prod_s1;
	logic [mjdc_pkg::HI_P_W-1:0]   hi_prod_s1;
	logic [mjdc_pkg::SUM_W-1:0]    sum;
	logic [mjdc_pkg::UNITS_W-1:0]  units_s2;
	logic [mjdc_pkg::UNITS_W-1:0]  units_s3;
	logic [mjdc_pkg::HOUR_P_W-1:0] hour_prod;
	logic [mjdc_pkg::HOUR_W-1:0]   hour_s4;
	logic [mjdc_pkg::UNITS_W-1:0]  units_s4;
	logic [mjdc_pkg::UNITS_W-1:0]  hour_base;
	logic [mjdc_pkg::UNITS_W-1:0]  rem_h_full;
	logic [mjdc_pkg::REM_H_W-1:0]  rem_h_s5;
	logic [mjdc_pkg::HOUR_W-1:0]   hour_s5;
	logic [mjdc_pkg::MIN_P_W-1:0]  min_prod;
	logic [mjdc_pkg::MINUTE_W-1:0] minute_s6;
	logic [mjdc_pkg::REM_H_W-1:0]  rem_h_s6;
	logic [mjdc_pkg::HOUR_W-1:0]   hour_s6;
	logic [mjdc_pkg::REM_H_W-1:0]  rem_m_full;
	mjdc_pkg::tod_t                tod_s7;
	mjdc_pkg::tod_t                tod_s8;
	mjdc_pkg::tod_t                tod_s9;

	assign sum = (mjdc_pkg::SUM_W'(hi_prod_s1) << mjdc_pkg::LO_BITS)
		+ mjdc_pkg::SUM_W'(lo_prod_s1)
		+ (mjdc_pkg::SUM_W'(1) << (mjdc_pkg::SCALE_SHIFT - 1));

	assign day_carry = (units_s2 >= mjdc_pkg::UNITS_W'(mjdc_pkg::UNITS_PER_DAY));

	assign hour_prod = mjdc_pkg::HOUR_P_W'(units_s3[mjdc_pkg::UNITS_W-1 -: mjdc_pkg::HOUR_X_W])
		* mjdc_pkg::HOUR_P_W'(mjdc_pkg::HOUR_R);

	assign hour_base = mjdc_pkg::UNITS_W'(hour_s4)
		* mjdc_pkg::UNITS_W'(mjdc_pkg::UNITS_PER_HOUR);
	assign rem_h_full = units_s4 - hour_base;

	assign min_prod = mjdc_pkg::MIN_P_W'(rem_h_s5[mjdc_pkg::REM_H_W-1 -: mjdc_pkg::MIN_X_W])
		* mjdc_pkg::MIN_P_W'(mjdc_pkg::MIN_R);

	assign rem_m_full = rem_h_s6 - mjdc_pkg::REM_H_W'(minute_s6)
		* mjdc_pkg::REM_H_W'(mjdc_pkg::UNITS_PER_MINUTE);

	always_ff @(posedge clk) begin
		if (adv) begin
			lo_prod_s1 <= mjdc_pkg::LO_P_W'(day_fraction[mjdc_pkg::LO_BITS-1:0])
				* mjdc_pkg::LO_P_W'(mjdc_pkg::SCALE_ODD);
			hi_prod_s1 <= mjdc_pkg::HI_P_W'(day_fraction[mjdc_pkg::FRAC_BITS-1:mjdc_pkg::LO_BITS])
				* mjdc_pkg::HI_P_W'(mjdc_pkg::SCALE_ODD);

			units_s2 <= sum[mjdc_pkg::SCALE_SHIFT +: mjdc_pkg::UNITS_W];

			units_s3 <= day_carry ? units_s2 - mjdc_pkg::UNITS_W'(mjdc_pkg::UNITS_PER_DAY)
				: units_s2;

			hour_s4  <= hour_prod[mjdc_pkg::HOUR_S +: mjdc_pkg::HOUR_W];
			units_s4 <= units_s3;

			rem_h_s5 <= rem_h_full[mjdc_pkg::REM_H_W-1:0];
			hour_s5  <= hour_s4;

			minute_s6 <= min_prod[mjdc_pkg::MIN_S +: mjdc_pkg::MINUTE_W];
			rem_h_s6  <= rem_h_s5;
			hour_s6   <= hour_s5;

			tod_s7.hour         <= hour_s6;
			tod_s7.minute       <= minute_s6;
			tod_s7.second_units <= rem_m_full[mjdc_pkg::SEC_W-1:0];

			tod_s8 <= tod_s7;
			tod_s9 <= tod_s8;
		end
	end

	assign tod = tod_s9;

endmodule

>>> design/mjdc_date_pipe.sv
// ----------------------------------------------------------------------------
// mjdc_date_pipe
// MJD day number to Gregorian year, month and day, nine register stages,
// with constant multiplies and reciprocal divisions in place of dividers.
// ----------------------------------------------------------------------------
module mjdc_date_pipe (
	input  logic                          clk,
	input  logic                          adv,
	input  logic [mjdc_pkg::DAY_BITS-1:0] mjd_day,
	input  logic                          day_carry,
	output mjdc_pkg::cal_date_t           cal_date
);

	logic [mjdc_pkg::DAY_BITS-1:0]  day_s1;
	logic [mjdc_pkg::DAY_BITS-1:0]  day_s2;
	logic [mjdc_pkg::TW-1:0]        t_s3;
	logic [mjdc_pkg::N_P_W-1:0]     n_prod;
	logic [mjdc_pkg::NW-1:0]        n_s4;
	logic [mjdc_pkg::TW-1:0]        t_s4;
	logic [mjdc_pkg::CYC_W-1:0]     cyc_days;
	logic [mjdc_pkg::CYC_W-1:0]     l1_full;
	logic [mjdc_pkg::L1W-1:0]       l1_s5;
	logic [mjdc_pkg::NW-1:0]        n_s5;
	logic [mjdc_pkg::Y1_XW-1:0]     y1_x;
	logic [mjdc_pkg::Y1_P_W-1:0]    y1_prod;
	logic [mjdc_pkg::Y1W-1:0]       y1_s6;
	logic [mjdc_pkg::L1W-1:0]       l1_s6;
	logic [mjdc_pkg::NW-1:0]        n_s6;
	logic [mjdc_pkg::L2_CALC_W-1:0] l2_full;
	logic [mjdc_pkg::L2W-1:0]       l2_s7;
	logic [mjdc_pkg::Y1W-1:0]       y1_s7;
	logic [mjdc_pkg::NW-1:0]        n_s7;
	logic [mjdc_pkg::M1_P_W-1:0]    m1_prod;
	logic [mjdc_pkg::M1W-1:0]       m1_s8;
	logic [mjdc_pkg::L2W-1:0]       l2_s8;
	logic [mjdc_pkg::Y1W-1:0]       y1_s8;
	logic [mjdc_pkg::NW-1:0]        n_s8;
	logic [mjdc_pkg::DD_P_W-1:0]    dd_prod;
	logic [mjdc_pkg::L2W-1:0]       mday_full;
	logic [mjdc_pkg::L3_P_W-1:0]    l3_prod;
	logic                           l3;
	logic [mjdc_pkg::M1W-1:0]       month_full;
	logic [mjdc_pkg::YEAR_W-1:0]    year_full;
	mjdc_pkg::cal_date_t            date_s9;

	assign n_prod = mjdc_pkg::N_P_W'(t_s3) * mjdc_pkg::N_P_W'(mjdc_pkg::N_R);

	assign cyc_days = (mjdc_pkg::CYC_W'(n_s4) * mjdc_pkg::CYC_W'(mjdc_pkg::CYCLE_DAYS)
		+ mjdc_pkg::CYC_W'(3)) >> 2;
	assign l1_full = mjdc_pkg::CYC_W'(t_s4) - cyc_days;

	assign y1_x    = mjdc_pkg::Y1_XW'(l1_s5) + mjdc_pkg::Y1_XW'(1);
	assign y1_prod = mjdc_pkg::Y1_P_W'(y1_x) * mjdc_pkg::Y1_P_W'(mjdc_pkg::Y1_R);

	assign l2_full = mjdc_pkg::L2_CALC_W'(l1_s6) + mjdc_pkg::L2_CALC_W'(mjdc_pkg::MARCH_BIAS)
		- ((mjdc_pkg::L2_CALC_W'(y1_s6) * mjdc_pkg::L2_CALC_W'(mjdc_pkg::QUAD_YEAR_DAYS)) >> 2);

	assign m1_prod = mjdc_pkg::M1_P_W'(l2_s7) * mjdc_pkg::M1_P_W'(mjdc_pkg::M1_R);

	assign dd_prod   = mjdc_pkg::DD_P_W'(m1_s8) * mjdc_pkg::DD_P_W'(mjdc_pkg::DD_R);
	assign mday_full = l2_s8 - mjdc_pkg::L2W'(dd_prod[mjdc_pkg::DD_S +: mjdc_pkg::DD_Q_W]);
	assign l3_prod   = mjdc_pkg::L3_P_W'(m1_s8) * mjdc_pkg::L3_P_W'(mjdc_pkg::L3_R);
	assign l3        = l3_prod[mjdc_pkg::L3_S];
	assign month_full = m1_s8 + mjdc_pkg::M1W'(mjdc_pkg::MONTH_BIAS)
		- mjdc_pkg::M1W'(mjdc_pkg::YEAR_MONTHS) * mjdc_pkg::M1W'(l3);
	assign year_full = mjdc_pkg::YEAR_W'(n_s8) * mjdc_pkg::YEAR_W'(mjdc_pkg::CENTURY_YEARS)
		+ mjdc_pkg::YEAR_W'(y1_s8) + mjdc_pkg::YEAR_W'(l3)
		- mjdc_pkg::YEAR_W'(mjdc_pkg::YEAR_BIAS);

	always_ff @(posedge clk) begin
		if (adv) begin
			day_s1 <= mjd_day;
			day_s2 <= day_s1;

			t_s3 <= mjdc_pkg::TW'(day_s2) + mjdc_pkg::TW'(mjdc_pkg::DAY_OFFSET)
				+ mjdc_pkg::TW'(day_carry);

			n_s4 <= n_prod[mjdc_pkg::N_S +: mjdc_pkg::NW];
			t_s4 <= t_s3;

			l1_s5 <= l1_full[mjdc_pkg::L1W-1:0];
			n_s5  <= n_s4;

			y1_s6 <= y1_prod[mjdc_pkg::Y1_S +: mjdc_pkg::Y1W];
			l1_s6 <= l1_s5;
			n_s6  <= n_s5;

			l2_s7 <= l2_full[mjdc_pkg::L2W-1:0];
			y1_s7 <= y1_s6;
			n_s7  <= n_s6;

			m1_s8 <= m1_prod[mjdc_pkg::M1_S +: mjdc_pkg::M1W];
			l2_s8 <= l2_s7;
			y1_s8 <= y1_s7;
			n_s8  <= n_s7;

			date_s9.year         <= year_full;
			date_s9.month        <= month_full;
			date_s9.day_of_month <= mday_full[mjdc_pkg::MDAY_W-1:0];
		end
	end

	assign cal_date = date_s9;

endmodule

>>> tb/mjdc_date_monitor.sv
// ----------------------------------------------------------------------------
// mjdc_date_monitor
// Watches both channels of the MJD to calendar converter. Predicts the date
// and time of day of every transaction taken on mjd, queues the predictions
// in order, and compares each transaction leaving cal field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module mjdc_date_monitor (
	input  logic clk,
	input  logic arst_n,
	mjdc_in_if   mjd,
	mjdc_out_if  cal,
	output int   mismatches,
	output int   awaited,
	output int   converted,
	output int   rollovers
);

	typedef struct packed {
		mjdc_pkg::cal_date_t date;
		mjdc_pkg::tod_t      tod;
	} stamp_t;

	localparam logic [63:0] DAY_UNITS    = 64'd8640000000;
	localparam logic [63:0] HOUR_UNITS   = 64'd360000000;
	localparam logic [63:0] MINUTE_UNITS = 64'd6000000;
	localparam logic [63:0] JD_OF_MJD0   = 64'd2400001;

	stamp_t pending_stamps[$];

	// Rounded time of day in 10 us units, then the integer Gregorian date steps.
	function automatic stamp_t mjd_to_stamp(input logic [mjdc_pkg::DAY_BITS-1:0] day_in,
		input logic [mjdc_pkg::FRAC_BITS-1:0] frac, output bit rolled);
		logic [127:0] scaled;
		logic [63:0]  units, day, rem, q, jd, cyc, l1, yr4, l2, mon, dom, tail, mo, yr;
		stamp_t       s;
		scaled = 128'(frac) * 128'(DAY_UNITS) + (128'd1 << (mjdc_pkg::FRAC_BITS - 1));
		units  = scaled[mjdc_pkg::FRAC_BITS +: 64];
		day    = 64'(day_in);
		rolled = (units >= DAY_UNITS);
		if (rolled) begin
			units = units - DAY_UNITS;
			day   = day + 64'd1;
		end
		q   = units / HOUR_UNITS;
		s.tod.hour = q[mjdc_pkg::HOUR_W-1:0];
		rem = units % HOUR_UNITS;
		q   = rem / MINUTE_UNITS;
		s.tod.minute = q[mjdc_pkg::MINUTE_W-1:0];
		rem = rem % MINUTE_UNITS;
		s.tod.second_units = rem[mjdc_pkg::SEC_W-1:0];

		jd   = day + JD_OF_MJD0;
		cyc  = (64'd4 * (jd + 64'd68569)) / 64'd146097;
		l1   = jd + 64'd68569 - (cyc * 64'd146097 + 64'd3) / 64'd4;
		yr4  = (64'd4000 * (l1 + 64'd1)) / 64'd1461001;
		l2   = l1 + 64'd31 - (64'd1461 * yr4) / 64'd4;
		mon  = (64'd80 * l2) / 64'd2447;
		dom  = l2 - (64'd2447 * mon) / 64'd80;
		tail = mon / 64'd11;
		mo   = mon + 64'd2 - 64'd12 * tail;
		yr   = 64'd100 * (cyc - 64'd49) + yr4 + tail;
		s.date.year         = yr[mjdc_pkg::YEAR_W-1:0];
		s.date.month        = mo[mjdc_pkg::MONTH_W-1:0];
		s.date.day_of_month = dom[mjdc_pkg::MDAY_W-1:0];
		return s;
	endfunction

	task automatic compare_field(input string name, input logic [63:0] want, input logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin : watch
		stamp_t want;
		bit     rolled;
		if (arst_n) begin
			if (mjd.valid && mjd.ready) begin
				pending_stamps.push_back(mjd_to_stamp(mjd.mjd_day, mjd.day_fraction, rolled));
				if (rolled)
					rollovers++;
			end
			if (cal.valid && cal.ready) begin
				if (pending_stamps.size() == 0) begin
					$error("unexpected transaction on cal: %0d-%0d-%0d %0d:%0d %0d",
						cal.year, cal.month, cal.day_of_month, cal.hour, cal.minute,
						cal.second_units);
					mismatches++;
				end else begin
					want = pending_stamps.pop_front();
					compare_field("year", 64'(want.date.year), 64'(cal.year));
					compare_field("month", 64'(want.date.month), 64'(cal.month));
					compare_field("day_of_month", 64'(want.date.day_of_month),
						64'(cal.day_of_month));
					compare_field("hour", 64'(want.tod.hour), 64'(cal.hour));
					compare_field("minute", 64'(want.tod.minute), 64'(cal.minute));
					compare_field("second_units", 64'(want.tod.second_units),
						64'(cal.second_units));
					converted++;
				end
			end
			awaited = pending_stamps.size();
		end
	end

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the MJD to calendar converter. Drives directed
// dates (epoch, top of range, leap and century days, rounding ties, day
// rollover) and then random timestamps under four flow-control mixes and one
// long output hold-off. The date monitor does all prediction and checking.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

	localparam int PHASE_ITEMS    = 222;
	localparam int PRESSURE_ITEMS = 40;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 20;

	localparam logic [mjdc_pkg::FRAC_BITS-1:0] FRAC_MAX = '1;
	localparam logic [mjdc_pkg::DAY_BITS-1:0]  DAY_MAX  = '1;

	logic clk;
	logic arst_n;

	int mismatches;
	int awaited;
	int converted;
	int rollovers;
	int send_idle_pct;
	int recv_stall_pct;
	int quiet_cycles;
	bit hold_req;

	mjdc_in_if  mjd_ch ();
	mjdc_out_if cal_ch ();

	modified_julian_day_to_calendar dut (
		.clk    (clk),
		.arst_n (arst_n),
		.mjd    (mjd_ch),
		.cal    (cal_ch)
	);

	mjdc_date_monitor monitor (
		.clk        (clk),
		.arst_n     (arst_n),
		.mjd        (mjd_ch),
		.cal        (cal_ch),
		.mismatches (mismatches),
		.awaited    (awaited),
		.converted  (converted),
		.rollovers  (rollovers)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [mjdc_pkg::DAY_BITS-1:0] pick_day();
		int unsigned sel;
		logic [31:0] r;
		sel = $urandom_range(99);
		if (sel < 40)
			r = $urandom;
		else if (sel < 70)
			r = $urandom_range(80000, 15000);
		else if (sel < 85)
			r = 32'(DAY_MAX) - $urandom_range(800);
		else
			r = $urandom_range(800);
		return r[mjdc_pkg::DAY_BITS-1:0];
	endfunction

	function automatic logic [mjdc_pkg::FRAC_BITS-1:0] pick_fraction();
		int unsigned  sel;
		logic [63:0]  w;
		logic [127:0] at;
		sel = $urandom_range(99);
		w   = {$urandom, $urandom};
		if (sel < 50) begin
			at = 128'(w);
		end else if (sel < 65) begin
			at = 128'(FRAC_MAX) - 128'($urandom_range(200));
		end else if (sel < 75) begin
			// exact half-unit ties
			at = 128'(2 * $urandom_range(4095) + 1) << 27;
		end else if (sel < 88) begin
			// near a minute boundary
			at = (128'($urandom_range(1439)) * 128'd6000000 << mjdc_pkg::FRAC_BITS)
				/ 128'd8640000000;
			at = at + 128'($urandom_range(6)) - 128'd3;
		end else begin
			at = 128'($urandom_range(1000));
		end
		return at[mjdc_pkg::FRAC_BITS-1:0];
	endfunction

	// Offer one transaction on mjd, with random gaps ahead of it.
	task automatic offer(input logic [mjdc_pkg::DAY_BITS-1:0] d,
		input logic [mjdc_pkg::FRAC_BITS-1:0] f);
		bit took;
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			mjd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		mjd_ch.valid        <= 1'b1;
		mjd_ch.mjd_day      <= d;
		mjd_ch.day_fraction <= f;
		do begin
			@(negedge clk);
			took = mjd_ch.ready;
			@(posedge clk);
		end while (!took);
	endtask

	// Receiver: random stalls, or a long hold-off on request.
	initial begin
		cal_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				cal_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				cal_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if ((mjd_ch.valid && mjd_ch.ready) || (cal_ch.valid && cal_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin : stimulus
		arst_n              = 1'b0;
		mjd_ch.valid        = 1'b0;
		mjd_ch.mjd_day      = '0;
		mjd_ch.day_fraction = '0;
		send_idle_pct       = 0;
		recv_stall_pct      = 0;
		hold_req            = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// epoch and top of the day range, with and without rollover
		offer('0, '0);
		offer('0, FRAC_MAX);
		offer(DAY_MAX, '0);
		offer(DAY_MAX, FRAC_MAX);
		// last fraction that stays in the day, first that rolls over
		offer('0, FRAC_MAX - 40'd63);
		offer('0, FRAC_MAX - 40'd62);
		offer(20'd51543, FRAC_MAX);
		offer(20'd51544, 40'h80_0000_0000);
		// leap day 2000, non-leap century years 1900 and 2100
		offer(20'd51603, 40'd0);
		offer(20'd51604, 40'd0);
		offer(20'd15078, 40'd0);
		offer(20'd15079, 40'd0);
		offer(20'd88127, 40'd0);
		offer(20'd88128, 40'd0);
		// half-unit ties round up
		offer(20'd60000, 40'h00_0800_0000);
		offer(20'd60000, 40'h00_07FF_FFFF);
		offer(20'd60000, 40'hFF_F800_0000);
		// first minute boundary
		offer(20'd51544, 40'd763549741);
		offer(20'd51544, 40'd763549742);

		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct  = 48;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 48;
				end
				default: begin
					send_idle_pct  = 26;
					recv_stall_pct = 26;
				end
			endcase
			repeat (PHASE_ITEMS) offer(pick_day(), pick_fraction());
		end

		// fill the pipeline against a held output
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_req       = 1'b1;
		repeat (PRESSURE_ITEMS) offer(pick_day(), pick_fraction());

		mjd_ch.valid <= 1'b0;
		@(posedge clk);
		while (awaited != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Checked %0d timestamps; %0d rounded up into the next day.",
			converted, rollovers);
		$display("Flow control: open, sender gaps, receiver stalls, mixed, %0d-cycle hold-off.",
			HOLD_CYCLES);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+design
design/mjdc_pkg.sv
design/mjdc_in_if.sv
design/mjdc_out_if.sv
design/mjdc_time_pipe.sv
design/mjdc_date_pipe.sv
design/modified_julian_day_to_calendar.sv
tb/mjdc_date_monitor.sv
tb/tb.sv
